// ----- src/csru_pkg.sv -----
// shared types and constants for the cache set replacement unit
package csru_pkg;

   localparam int TAG_W         = 32;
   localparam int BLOCK_BYTES_W = 11;
   localparam int COST_W        = 16;
   localparam int FILL_W        = 16;
   localparam int SUM_W         = 18;
   localparam int CSR_INDEX_W   = 2;

   // access costs in cycles
   localparam logic [SUM_W-1:0] HIT_COST           = 18'd1;
   localparam logic [SUM_W-1:0] MEM_WRITE_COST     = 18'd100;
   localparam logic [6:0]       FILL_COST_PER_WORD = 7'd100;
   localparam logic [SUM_W-1:0] COST_MAX           = 18'd65535;

   // register reset values
   localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RESET = 11'd16;

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_STORE = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCK_BYTES    = 2'd0,
      CSR_WRITE_ALLOCATE = 2'd1,
      CSR_WRITE_THROUGH  = 2'd2,
      CSR_USE_LRU        = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_busy;
   } status_type;

endpackage

// ----- src/csru_ctrl.sv -----
// sequencer for capture, lookup and commit of one access
module csru_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  csru_pkg::status_type status,
   output csru_pkg::cmd_type    cmd
);

   csru_pkg::state_type state_ff;
   csru_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csru_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csru_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = csru_pkg::ST_LOOKUP;
         end
         csru_pkg::ST_LOOKUP: begin
            state_in = csru_pkg::ST_COMMIT;
         end
         csru_pkg::ST_COMMIT: begin
            if (!status.rsp_busy) state_in = csru_pkg::ST_IDLE;
         end
         default: begin
            state_in = csru_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         csru_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         csru_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         csru_pkg::ST_COMMIT: begin
            cmd.commit = !status.rsp_busy;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ----- src/csru_datapath.sv -----
// way state, tag compare, age update, cost sum and result register
module csru_datapath #(
   parameter int WAYS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  csru_pkg::cmd_type                   cmd,
   output csru_pkg::status_type                status,
   input  logic [0:0]                          req_tuser,
   input  logic [csru_pkg::TAG_W-1:0]          req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [0:0]                          rsp_tuser,
   output logic [csru_pkg::COST_W-1:0]         rsp_tdata,
   input  logic                                csr_valid,
   input  logic [csru_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [csru_pkg::BLOCK_BYTES_W-1:0]  csr_data
);

   localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CNT_W = $clog2(WAYS + 1);
   localparam logic [AGE_W-1:0] OLDEST = AGE_W'(WAYS - 1);
   localparam logic [CNT_W-1:0] FULL   = CNT_W'(WAYS);

   // configuration
   logic [csru_pkg::BLOCK_BYTES_W-1:0] block_bytes_ff;
   logic                               write_allocate_ff;
   logic                               write_through_ff;
   logic                               use_lru_ff;

   // set state
   logic                        way_valid_ff [WAYS];
   logic                        way_valid_in [WAYS];
   logic [csru_pkg::TAG_W-1:0]  way_tag_ff   [WAYS];
   logic [csru_pkg::TAG_W-1:0]  way_tag_in   [WAYS];
   logic                        way_dirty_ff [WAYS];
   logic                        way_dirty_in [WAYS];
   logic [AGE_W-1:0]            way_age_ff   [WAYS];
   logic [AGE_W-1:0]            way_age_in   [WAYS];
   logic [CNT_W-1:0]            filled_count_ff;
   logic [CNT_W-1:0]            filled_count_in;

   // captured access
   csru_pkg::op_type            op_ff;
   logic [csru_pkg::TAG_W-1:0]  tag_ff;

   // lookup results
   logic                        hit_c, hit_ff;
   logic [AGE_W-1:0]            hit_way_c, hit_way_ff;
   logic [AGE_W-1:0]            hit_age_c, hit_age_ff;
   logic [AGE_W-1:0]            empty_way_c;
   logic [AGE_W-1:0]            victim_way_c;
   logic                        victim_dirty_c;
   logic                        use_empty_c, use_empty_ff;
   logic [AGE_W-1:0]            fill_way_ff;
   logic                        victim_dirty_ff;
   logic [csru_pkg::FILL_W-1:0] fill_cost_ff;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff;
   logic [csru_pkg::COST_W-1:0] rsp_cost_ff, rsp_cost_in;

   logic                        is_store;
   logic                        allocate;
   logic [csru_pkg::SUM_W-1:0]  cost_sum;

   assign is_store = (op_ff == csru_pkg::OP_STORE);
   assign allocate = !hit_ff && (!is_store || write_allocate_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff    <= csru_pkg::BLOCK_BYTES_RESET;
         write_allocate_ff <= 1'b1;
         write_through_ff  <= 1'b0;
         use_lru_ff        <= 1'b1;
      end else if (csr_valid) begin
         unique case (csru_pkg::csr_index_type'(csr_index))
            csru_pkg::CSR_BLOCK_BYTES:    block_bytes_ff    <= csr_data;
            csru_pkg::CSR_WRITE_ALLOCATE: write_allocate_ff <= csr_data[0];
            csru_pkg::CSR_WRITE_THROUGH:  write_through_ff  <= csr_data[0];
            csru_pkg::CSR_USE_LRU:        use_lru_ff        <= csr_data[0];
            default:                      use_lru_ff        <= use_lru_ff;
         endcase
      end
   end

   // access capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= csru_pkg::op_type'(req_tuser);
         tag_ff <= req_tdata;
      end
   end

   // parallel compare, lowest index wins
   always_comb begin
      hit_c          = 1'b0;
      hit_way_c      = '0;
      hit_age_c      = '0;
      empty_way_c    = '0;
      victim_way_c   = '0;
      victim_dirty_c = 1'b0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (way_valid_ff[i] && (way_tag_ff[i] == tag_ff)) begin
            hit_c     = 1'b1;
            hit_way_c = AGE_W'(i);
            hit_age_c = way_age_ff[i];
         end
         if (!way_valid_ff[i]) begin
            empty_way_c = AGE_W'(i);
         end
         if (way_age_ff[i] == OLDEST) begin
            victim_way_c   = AGE_W'(i);
            victim_dirty_c = way_dirty_ff[i];
         end
      end
      use_empty_c = (filled_count_ff < FULL);
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff          <= hit_c;
         hit_way_ff      <= hit_way_c;
         hit_age_ff      <= hit_age_c;
         use_empty_ff    <= use_empty_c;
         fill_way_ff     <= use_empty_c ? empty_way_c : victim_way_c;
         victim_dirty_ff <= !use_empty_c && victim_dirty_c;
         fill_cost_ff    <= csru_pkg::FILL_W'(block_bytes_ff[csru_pkg::BLOCK_BYTES_W-1:2])
                            * csru_pkg::FILL_W'(csru_pkg::FILL_COST_PER_WORD);
      end
   end

   // set update on commit
   always_comb begin
      filled_count_in = filled_count_ff;
      for (int i = 0; i < WAYS; i++) begin
         way_valid_in[i] = way_valid_ff[i];
         way_tag_in[i]   = way_tag_ff[i];
         way_dirty_in[i] = way_dirty_ff[i];
         way_age_in[i]   = way_age_ff[i];
      end
      if (cmd.commit) begin
         if (hit_ff) begin
            for (int i = 0; i < WAYS; i++) begin
               if (use_lru_ff && way_valid_ff[i]) begin
                  if (way_age_ff[i] == hit_age_ff) begin
                     way_age_in[i] = '0;
                  end else if (way_age_ff[i] < hit_age_ff) begin
                     way_age_in[i] = way_age_ff[i] + 1'b1;
                  end
               end
               if ((AGE_W'(i) == hit_way_ff) && is_store && !write_through_ff) begin
                  way_dirty_in[i] = 1'b1;
               end
            end
         end else if (allocate) begin
            if (use_empty_ff) begin
               filled_count_in = filled_count_ff + 1'b1;
            end
            for (int i = 0; i < WAYS; i++) begin
               // the victim holds the oldest age, so every other valid way ages
               if (way_valid_ff[i]) begin
                  way_age_in[i] = way_age_ff[i] + 1'b1;
               end
               if (AGE_W'(i) == fill_way_ff) begin
                  way_valid_in[i] = 1'b1;
                  way_tag_in[i]   = tag_ff;
                  way_age_in[i]   = '0;
                  way_dirty_in[i] = is_store && !write_through_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_count_ff <= '0;
         for (int i = 0; i < WAYS; i++) begin
            way_valid_ff[i] <= 1'b0;
            way_tag_ff[i]   <= '0;
            way_dirty_ff[i] <= 1'b0;
            way_age_ff[i]   <= '0;
         end
      end else begin
         filled_count_ff <= filled_count_in;
         for (int i = 0; i < WAYS; i++) begin
            way_valid_ff[i] <= way_valid_in[i];
            way_tag_ff[i]   <= way_tag_in[i];
            way_dirty_ff[i] <= way_dirty_in[i];
            way_age_ff[i]   <= way_age_in[i];
         end
      end
   end

   // access cost
   always_comb begin
      if (hit_ff) begin
         cost_sum = csru_pkg::HIT_COST
                  + ((is_store && write_through_ff) ? csru_pkg::MEM_WRITE_COST : '0);
      end else if (allocate) begin
         cost_sum = csru_pkg::SUM_W'(fill_cost_ff)
                  + (victim_dirty_ff ? csru_pkg::SUM_W'(fill_cost_ff) : '0)
                  + (is_store ? (write_through_ff ? csru_pkg::MEM_WRITE_COST
                                                  : csru_pkg::HIT_COST) : '0);
      end else begin
         cost_sum = csru_pkg::MEM_WRITE_COST;
      end
      rsp_cost_in = (cost_sum > csru_pkg::COST_MAX) ? '1 : cost_sum[csru_pkg::COST_W-1:0];
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff  <= hit_ff;
         rsp_cost_ff <= rsp_cost_in;
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tuser       = rsp_hit_ff;
   assign rsp_tdata       = rsp_cost_ff;

endmodule

// ----- src/cache_set_replacement_model_unit.sv -----
// top level of the cache set replacement unit
//
// Models one set of a WAYS-way associative cache. Each request transfer is a
// load or a store of one tag; each response transfer reports hit or miss and
// the cycles that access costs. Fills go to the first empty way, otherwise the
// oldest way is evicted under LRU or FIFO order; write-allocate, write-through
// and block size are set through the csr port, which is to be written by the user
// only while no access is in flight; the block itself does not enforce this. An
// access runs through capture, lookup (all ways compared in parallel and the fill
// cost multiplied out) and commit (ages, tags and dirty bits updated, cost summed
// and saturated into the response register). Commit waits while the response
// register still holds an untaken result, but a new request is taken as soon as
// commit is done, and never before, so one access is in flight at a time. The set
// state resets at once; there is no clearing pass.
module cache_set_replacement_model_unit #(
   parameter int WAYS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tuser = operation, tdata = tag
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [0:0]                          req_tuser,   // [0] operation
   input  logic [csru_pkg::TAG_W-1:0]          req_tdata,   // [31:0] tag
   // response: tuser = hit, tdata = cycle_cost
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [0:0]                          rsp_tuser,   // [0] hit
   output logic [csru_pkg::COST_W-1:0]         rsp_tdata,   // [15:0] cycle_cost
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [csru_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [csru_pkg::BLOCK_BYTES_W-1:0]  csr_data
);

   csru_pkg::cmd_type    cmd;
   csru_pkg::status_type status;

   // registers can always be written
   assign csr_ready = 1'b1;

   // sequencer
   csru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // set state and result path
   csru_datapath #(
      .WAYS (WAYS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule

// ----- src/csru_checker.sv -----
// port checker for the cache set replacement unit and its bind
module csru_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [0:0]  rsp_tuser,
   input logic [15:0] rsp_tdata
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one access at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an access is in flight");

   // a hit's cost is 1, plus the memory write cost when written through
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 16'd1 || rsp_tdata == 16'd101)
      else $error("hit with unexpected cost");

   // a fresh response follows a request transfer that went through the lookup and commit states
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3))
      else $error("response without matching request");

endmodule

bind cache_set_replacement_model_unit csru_checker u_csru_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/cache_set_replacement_model_checker.sv -----
`timescale 1ns / 100ps
// response checker for the cache set replacement unit: tracks the set and compares every result
module cache_set_replacement_model_checker #(
   parameter int WAYS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [0:0]                          req_tuser,
   input  logic [csru_pkg::TAG_W-1:0]          req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [0:0]                          rsp_tuser,
   input  logic [csru_pkg::COST_W-1:0]         rsp_tdata,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [csru_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [csru_pkg::BLOCK_BYTES_W-1:0]  csr_data,
   output int                                  fail_count,
   output int                                  outstanding,
   output int                                  hit_total,
   output int                                  miss_total,
   output int                                  dirty_evict_total,
   output int                                  saturate_total
);

   localparam int unsigned HIT_CYCLES        = 1;
   localparam int unsigned MEM_WRITE_CYCLES  = 100;
   localparam int unsigned CYCLES_PER_WORD   = 100;
   localparam int unsigned COST_CEILING      = 65535;

   typedef struct packed {
      logic                        hit;
      logic [csru_pkg::COST_W-1:0] cycle_cost;
   } access_result_type;

   // shadow of the set and its registers
   logic                               way_valid [WAYS];
   logic [csru_pkg::TAG_W-1:0]         way_tag   [WAYS];
   logic                               way_dirty [WAYS];
   int unsigned                        way_age   [WAYS];
   int                                 filled_ways;
   logic [csru_pkg::BLOCK_BYTES_W-1:0] cfg_block_bytes;
   logic                               cfg_write_allocate;
   logic                               cfg_write_through;
   logic                               cfg_use_lru;

   access_result_type pending_results [$];
   int errors, hits, misses, dirty_evicts, saturated;

   initial begin
      errors       = 0;
      hits         = 0;
      misses       = 0;
      dirty_evicts = 0;
      saturated    = 0;
   end

   // way at age pivot becomes youngest, younger valid ways age by one
   task automatic promote_way(input int unsigned pivot);
      int i;
      for (i = 0; i < WAYS; i++) begin
         if (way_valid[i]) begin
            if (way_age[i] == pivot) way_age[i] = 0;
            else if (way_age[i] < pivot) way_age[i] = way_age[i] + 1;
         end
      end
   endtask

   // brings tag into the set, adds fill and write-back cycles
   task automatic fill_way(input logic [csru_pkg::TAG_W-1:0] tag, inout int unsigned cost,
                           output int slot);
      int unsigned fill;
      int          i;
      int          empty;
      bit          oldest_found;
      fill  = (int'(cfg_block_bytes) / 4) * CYCLES_PER_WORD;
      empty = -1;
      if (filled_ways < WAYS) begin
         for (i = WAYS - 1; i >= 0; i--) if (!way_valid[i]) empty = i;
      end
      if (empty >= 0) begin
         for (i = 0; i < WAYS; i++) if (way_valid[i]) way_age[i] = way_age[i] + 1;
         way_valid[empty] = 1'b1;
         way_tag[empty]   = tag;
         way_dirty[empty] = 1'b0;
         way_age[empty]   = 0;
         filled_ways++;
         cost += fill;
         slot = empty;
      end else begin
         // oldest way, or the first with the greatest age if none is oldest
         slot         = 0;
         oldest_found = 1'b0;
         for (i = 0; i < WAYS; i++) begin
            if (!oldest_found) begin
               if (way_age[i] == WAYS - 1) begin
                  slot         = i;
                  oldest_found = 1'b1;
               end else if (way_age[i] > way_age[slot]) begin
                  slot = i;
               end
            end
         end
         promote_way(way_age[slot]);
         way_age[slot]   = 0;
         way_valid[slot] = 1'b1;
         way_tag[slot]   = tag;
         if (way_dirty[slot]) begin
            cost += fill;
            dirty_evicts++;
         end
         way_dirty[slot] = 1'b0;
         cost += fill;
      end
   endtask

   task automatic access_set(input csru_pkg::op_type op, input logic [csru_pkg::TAG_W-1:0] tag,
                             output access_result_type result);
      int unsigned cost;
      int          found;
      int          i;
      int          slot;
      cost  = 0;
      found = -1;
      for (i = WAYS - 1; i >= 0; i--) begin
         if (way_valid[i] && way_tag[i] == tag) found = i;
      end
      if (found >= 0) begin
         if (cfg_use_lru) promote_way(way_age[found]);
         if (op == csru_pkg::OP_STORE) begin
            if (cfg_write_through) cost += MEM_WRITE_CYCLES;
            else way_dirty[found] = 1'b1;
         end
         cost += HIT_CYCLES;
         hits++;
      end else begin
         misses++;
         if (op == csru_pkg::OP_LOAD) begin
            fill_way(tag, cost, slot);
         end else if (cfg_write_allocate) begin
            fill_way(tag, cost, slot);
            if (cfg_write_through) begin
               cost += MEM_WRITE_CYCLES;
            end else begin
               way_dirty[slot] = 1'b1;
               cost += HIT_CYCLES;
            end
         end else begin
            cost += MEM_WRITE_CYCLES;
         end
      end
      if (cost > COST_CEILING) begin
         cost = COST_CEILING;
         saturated++;
      end
      result.hit        = (found >= 0);
      result.cycle_cost = cost[csru_pkg::COST_W-1:0];
   endtask

   always @(posedge clock) begin
      access_result_type predicted;
      int                i;
      if (reset) begin
         for (i = 0; i < WAYS; i++) begin
            way_valid[i] = 1'b0;
            way_tag[i]   = '0;
            way_dirty[i] = 1'b0;
            way_age[i]   = 0;
         end
         filled_ways        = 0;
         cfg_block_bytes    = csru_pkg::BLOCK_BYTES_RESET;
         cfg_write_allocate = 1'b1;
         cfg_write_through  = 1'b0;
         cfg_use_lru        = 1'b1;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               csru_pkg::CSR_BLOCK_BYTES:    cfg_block_bytes    = csr_data;
               csru_pkg::CSR_WRITE_ALLOCATE: cfg_write_allocate = csr_data[0];
               csru_pkg::CSR_WRITE_THROUGH:  cfg_write_through  = csr_data[0];
               csru_pkg::CSR_USE_LRU:        cfg_use_lru        = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            access_set(csru_pkg::op_type'(req_tuser[0]), req_tdata, predicted);
            pending_results.insert(pending_results.size(), predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t ns: response transfer with no access outstanding, got hit %0d cost %0d",
                        $time, rsp_tuser[0], rsp_tdata);
               errors++;
            end else begin
               predicted = pending_results.pop_front();
               if (rsp_tuser[0] !== predicted.hit) begin
                  $display("%0t ns: hit mismatch, expected %0d, got %0d",
                           $time, predicted.hit, rsp_tuser[0]);
                  errors++;
               end
               if (rsp_tdata !== predicted.cycle_cost) begin
                  $display("%0t ns: cycle_cost mismatch, expected %0d, got %0d",
                           $time, predicted.cycle_cost, rsp_tdata);
                  errors++;
               end
            end
         end
      end
      fail_count        <= errors;
      outstanding       <= pending_results.size();
      hit_total         <= hits;
      miss_total        <= misses;
      dirty_evict_total <= dirty_evicts;
      saturate_total    <= saturated;
   end

endmodule

// ----- sim/tb_cache_set_replacement_model_unit.sv -----
`timescale 1ns / 100ps
// testbench top for the cache set replacement unit: stimulus, response pacing and verdict
module tb_cache_set_replacement_model_unit;
   import csru_pkg::*;

   localparam int WAYS            = 4;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 108;
   localparam int TAG_POOL        = 6;       // a few more tags than ways keeps hits and evictions mixed

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [0:0]               req_tuser  = '0;   // [0] operation
   logic [TAG_W-1:0]         req_tdata  = '0;   // [31:0] tag
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [0:0]               rsp_tuser;         // [0] hit
   logic [COST_W-1:0]        rsp_tdata;         // [15:0] cycle_cost
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index  = '0;
   logic [BLOCK_BYTES_W-1:0] csr_data   = '0;

   int fail_count;
   int outstanding;
   int hit_total;
   int miss_total;
   int dirty_evict_total;
   int saturate_total;

   int accesses_sent = 0;
   int config_count  = 0;
   int burst_left    = 0;
   bit sender_gaps   = 1'b0;
   int stall_pct     = 0;
   int rsp_stall_left = 0;
   int cycle_count;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   cache_set_replacement_model_unit #(
      .WAYS(WAYS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   cache_set_replacement_model_checker #(
      .WAYS(WAYS)
   ) set_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tuser         (req_tuser),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tuser         (rsp_tuser),
      .rsp_tdata         (rsp_tdata),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .hit_total         (hit_total),
      .miss_total        (miss_total),
      .dirty_evict_total (dirty_evict_total),
      .saturate_total    (saturate_total)
   );

   // response sink: random stalls of random length, rate set per phase by stall_pct
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if ($urandom_range(99, 0) < stall_pct) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= $urandom_range(7, 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one request transfer; valid stays high on return so bursts run back to back
   task automatic send_access(input op_type op, input logic [TAG_W-1:0] tag);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= tag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accesses_sent++;
   endtask

   // bursts of random length, with a random gap between bursts when gaps are on
   task automatic pace_sender();
      if (burst_left == 0) begin
         if (sender_gaps) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clock);
         end
         burst_left = $urandom_range(20, 1);
      end
      burst_left--;
   endtask

   task automatic write_field(input csr_index_type idx, input logic [BLOCK_BYTES_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // registers change only once every access has been answered
   task automatic set_config(input logic [BLOCK_BYTES_W-1:0] block_bytes, input logic allocate,
                             input logic through, input logic lru);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // one-bit registers get random upper data bits, only bit 0 counts
      write_field(CSR_BLOCK_BYTES, block_bytes);
      write_field(CSR_WRITE_ALLOCATE, {10'($urandom_range(1023, 0)), allocate});
      write_field(CSR_WRITE_THROUGH, {10'($urandom_range(1023, 0)), through});
      write_field(CSR_USE_LRU, {10'($urandom_range(1023, 0)), lru});
      csr_valid <= 1'b0;
      config_count++;
   endtask

   // run timeout
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timed out after %0d cycles with %0d responses outstanding",
               cycle_count, outstanding);
      $display("cache_set_replacement_model_unit verification failed");
      $finish;
   end

   initial begin
      int                       p;
      int                       n;
      int                       k;
      int                       store_pct;
      op_type                   op;
      logic [TAG_W-1:0]         tag;
      logic [TAG_W-1:0]         tag_pool [TAG_POOL];
      logic [BLOCK_BYTES_W-1:0] block_sizes [RANDOM_PHASES];

      block_sizes = '{11'd4, 11'd1024, 11'd16, 11'd2047, 11'd64,
                      11'd0, 11'd256, 11'd3, 11'd8, 11'd1024};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings are 16-byte blocks, write-allocate, write-back, lru
      stall_pct <= 30;
      send_access(OP_LOAD, 32'h0000_0000);    // cold miss into way 0
      send_access(OP_STORE, 32'hFFFF_FFFF);   // store miss allocates, way left dirty
      send_access(OP_LOAD, 32'h0000_0000);    // load hit refreshes lru order
      send_access(OP_STORE, 32'h0000_0000);   // store hit marks dirty
      send_access(OP_LOAD, 32'hA5A5_A5A5);
      send_access(OP_LOAD, 32'h5A5A_5A5A);    // set now full
      send_access(OP_LOAD, 32'h1234_5678);    // evicts the dirty oldest way, write-back added

      // no-allocate, write-through
      set_config(11'd16, 1'b0, 1'b1, 1'b1);
      send_access(OP_STORE, 32'h0000_0000);   // store hit writes through
      send_access(OP_STORE, 32'hDEAD_BEEF);   // store miss goes to memory only

      // fifo order: hits leave ages alone
      set_config(11'd16, 1'b1, 1'b1, 1'b0);
      send_access(OP_STORE, 32'hCAFE_F00D);   // allocate plus write-through
      send_access(OP_LOAD, 32'h0000_0000);

      // block smaller than one word costs nothing to fill
      set_config(11'd2, 1'b1, 1'b0, 1'b0);
      send_access(OP_LOAD, 32'h1111_1111);
      send_access(OP_STORE, 32'h2222_2222);

      // largest block size: dirty victims push the cost past 16 bits, so it saturates
      set_config(11'd2047, 1'b1, 1'b0, 1'b0);
      for (k = 0; k < WAYS; k++) send_access(OP_STORE, 32'h3333_0000 + k);

      // block size range ends and the zero size
      set_config(11'd1024, 1'b1, 1'b0, 1'b1);
      send_access(OP_LOAD, 32'h4444_4444);
      set_config(11'd4, 1'b1, 1'b0, 1'b1);
      send_access(OP_LOAD, 32'h5555_5555);
      set_config(11'd0, 1'b1, 1'b0, 1'b1);
      send_access(OP_LOAD, 32'h6666_6666);

      // random phases: every allocate/through/lru combination, block size extremes,
      // a small tag pool so hits, fills and evictions all keep happening
      for (p = 0; p < RANDOM_PHASES; p++) begin
         set_config(block_sizes[p], p[0], p[1], (p < 8) ? p[2] : 1'($urandom_range(1, 0)));
         for (k = 0; k < TAG_POOL; k++) tag_pool[k] = $urandom;
         store_pct   = $urandom_range(70, 30);
         // every third phase runs with no idling on either side
         sender_gaps = (p % 3 != 0);
         stall_pct  <= (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 20 : 60);
         burst_left  = 0;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            pace_sender();
            op  = ($urandom_range(99, 0) < store_pct) ? OP_STORE : OP_LOAD;
            tag = ($urandom_range(99, 0) < 85) ? tag_pool[$urandom_range(TAG_POOL - 1, 0)]
                                               : $urandom;
            send_access(op, tag);
         end
      end

      // drain, then a short settle with the sink still pacing
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("run covered %0d accesses under %0d register settings: %0d hits, %0d misses",
               accesses_sent, config_count + 1, hit_total, miss_total);
      $display("dirty victims written back: %0d, costs saturated at 16 bits: %0d",
               dirty_evict_total, saturate_total);
      if (fail_count == 0) begin
         $display("cache_set_replacement_model_unit verification clean");
      end else begin
         $display("cache_set_replacement_model_unit verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/csru_pkg.sv
src/csru_ctrl.sv
src/csru_datapath.sv
src/cache_set_replacement_model_unit.sv
src/csru_checker.sv
sim/cache_set_replacement_model_checker.sv
sim/tb_cache_set_replacement_model_unit.sv
